/* hw/rtl/sawkm_pkg.sv */
package sawkm_pkg;

	// Event kinds carried in the input tuser
	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_SELECT = 2'd1,
		OP_INC    = 2'd2,
		OP_DEC    = 2'd3
	} op_t;

	// Menu items
	localparam logic [2:0] ITEM_TEMP  = 3'd0;
	localparam logic [2:0] ITEM_HUMID = 3'd1;
	localparam logic [2:0] ITEM_GAS   = 3'd2;
	localparam logic [2:0] ITEM_NOISE = 3'd3;
	localparam logic [2:0] ITEM_LIGHT = 3'd4;
	localparam logic [2:0] ITEM_EXIT  = 3'd5;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int FIELD_BITS      = 12;

	// Limit ranges, steps and reset values
	localparam logic [5:0]  TEMP_MIN   = 6'd10;
	localparam logic [5:0]  TEMP_MAX   = 6'd40;
	localparam logic [5:0]  TEMP_RST   = 6'd20;
	localparam logic [6:0]  HUMID_MIN  = 7'd60;
	localparam logic [6:0]  HUMID_MAX  = 7'd100;
	localparam logic [6:0]  HUMID_RST  = 7'd90;
	localparam logic [11:0] GAS_MIN    = 12'd2000;
	localparam logic [11:0] GAS_MAX    = 12'd3000;
	localparam logic [11:0] GAS_RST    = 12'd2000;
	localparam logic [11:0] GAS_STEP   = 12'd100;
	localparam logic [10:0] NOISE_MIN  = 11'd1000;
	localparam logic [10:0] NOISE_MAX  = 11'd2000;
	localparam logic [10:0] NOISE_RST  = 11'd2000;
	localparam logic [10:0] NOISE_STEP = 11'd100;
	localparam logic [8:0]  LIGHT_MIN  = 9'd100;
	localparam logic [8:0]  LIGHT_MAX  = 9'd300;
	localparam logic [8:0]  LIGHT_RST  = 9'd300;
	localparam logic [8:0]  LIGHT_STEP = 9'd10;

	localparam int IN_DATA_BITS  = 56;
	localparam int OUT_DATA_BITS = 24;

	// Input payload, last member in the lowest bits
	typedef struct packed {
		logic [2:0]  pad;
		logic [11:0] light_level;
		logic [11:0] noise_level;
		logic [11:0] gas_level;
		logic [7:0]  temperature;
		logic [7:0]  humidity;
		logic        climate_valid;
	} in_data_t;

	// Result payload, last member in the lowest bits
	typedef struct packed {
		logic        pad;
		logic        save_request;
		logic        motor_request;
		logic        light_strong;
		logic        gas_alarm;
		logic        noise_alarm;
		logic        heat_relay;
		logic        humidity_alarm;
		logic [11:0] item_value;
		logic [2:0]  menu_item;
		logic        in_menu;
	} out_data_t;

endpackage

/* hw/rtl/sensor_alarm_with_key_menu.sv */
// Sensor alarm block with a three-key limit editing menu.
//
// Input channel s_axis: one transfer is one event. tuser carries the kind
// (sample, select, increase, decrease), tdata the climate and converter
// readings. Output channel m_axis: exactly one result transfer per event,
// in order, with the menu position, the limit of the selected item, the
// latched alarms and the per-event pulses.
//
// Each event passes the input register and then the result register
// before its result shows on m_axis. One event is taken every cycle:
// an input register feeds a single pass of compares and wrap adds and
// subtracts on the limit registers, which loads the result register,
// so the sustained rate is one item per cycle whenever the receiver takes
// results as fast.
//
// When the receiver stalls, the result register holds its item and the
// input register fills; s_axis_tready drops only when both are occupied.
// Reset clears both stages, leaves the menu, sets the limits to their
// defaults and clears all alarms.
module sensor_alarm_with_key_menu
	import sawkm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// climate_valid, humidity, temperature, gas_level, noise_level, light_level, zero fill
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	// op
	input  logic [1:0]               s_axis_tuser,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// in_menu, menu_item, item_value, humidity_alarm, heat_relay, noise_alarm,
	// gas_alarm, light_strong, motor_request, save_request, zero fill
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

	localparam int USED_BITS = (SAMPLE_BITS < FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
	localparam logic [FIELD_BITS-1:0] SAMPLE_MASK = FIELD_BITS'((1 << USED_BITS) - 1);

	logic      valid_s1;
	in_data_t  data_s1;
	op_t       op_s1;
	logic      valid_s2;
	out_data_t data_s2;

	logic        menu_q;
	logic [2:0]  item_q;
	logic [5:0]  temp_lim_q;
	logic [6:0]  humid_lim_q;
	logic [11:0] gas_lim_q;
	logic [10:0] noise_lim_q;
	logic [8:0]  light_lim_q;
	logic        humid_flag_q;
	logic        relay_flag_q;
	logic        noise_flag_q;
	logic        gas_flag_q;

	logic        menu_d;
	logic [2:0]  item_d;
	logic [5:0]  temp_lim_d;
	logic [6:0]  humid_lim_d;
	logic [11:0] gas_lim_d;
	logic [10:0] noise_lim_d;
	logic [8:0]  light_lim_d;
	logic        humid_flag_d;
	logic        relay_flag_d;
	logic        noise_flag_d;
	logic        gas_flag_d;
	logic        light_strong;
	logic        motor_req;
	logic        save_req;
	logic [11:0] item_value;
	logic [11:0] gas_m;
	logic [11:0] noise_m;
	logic [11:0] light_m;
	logic        out_load;
	logic        advance;
	out_data_t   result;

	// Handshake: result register frees when taken, input stage moves on then
	assign out_load      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_load;
	assign s_axis_tready = !valid_s1 || out_load;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= in_data_t'(s_axis_tdata);
			op_s1   <= op_t'(s_axis_tuser);
		end
	end

	// Mask converter samples to the used width
	assign gas_m   = data_s1.gas_level & SAMPLE_MASK;
	assign noise_m = data_s1.noise_level & SAMPLE_MASK;
	assign light_m = data_s1.light_level & SAMPLE_MASK;

	// Next state for one event
	always_comb begin
		menu_d       = menu_q;
		item_d       = item_q;
		temp_lim_d   = temp_lim_q;
		humid_lim_d  = humid_lim_q;
		gas_lim_d    = gas_lim_q;
		noise_lim_d  = noise_lim_q;
		light_lim_d  = light_lim_q;
		humid_flag_d = humid_flag_q;
		relay_flag_d = relay_flag_q;
		noise_flag_d = noise_flag_q;
		gas_flag_d   = gas_flag_q;
		light_strong = 1'b0;
		motor_req    = 1'b0;
		save_req     = 1'b0;
		unique case (op_s1)
			OP_SAMPLE: begin
				if (!menu_q) begin
					if (data_s1.climate_valid) begin
						humid_flag_d = data_s1.humidity > {1'b0, humid_lim_q};
						motor_req    = humid_flag_d;
						relay_flag_d = data_s1.temperature > {2'b00, temp_lim_q};
					end
					noise_flag_d = noise_m > {1'b0, noise_lim_q};
					gas_flag_d   = gas_m > gas_lim_q;
					light_strong = light_m < {3'b000, light_lim_q};
				end
			end
			OP_SELECT: begin
				if (!menu_q) begin
					menu_d = 1'b1;
					item_d = ITEM_TEMP;
				end else if (item_q >= ITEM_EXIT) begin
					menu_d   = 1'b0;
					item_d   = ITEM_TEMP;
					save_req = 1'b1;
				end else begin
					item_d = item_q + 3'd1;
				end
			end
			OP_INC: begin
				if (menu_q) begin
					case (item_q)
						ITEM_TEMP:  temp_lim_d  = (temp_lim_q >= TEMP_MAX) ? TEMP_MIN
							: temp_lim_q + 6'd1;
						ITEM_HUMID: humid_lim_d = (humid_lim_q >= HUMID_MAX) ? HUMID_MIN
							: humid_lim_q + 7'd1;
						ITEM_GAS:   gas_lim_d   = (gas_lim_q >= GAS_MAX) ? GAS_MIN
							: gas_lim_q + GAS_STEP;
						ITEM_NOISE: noise_lim_d = (noise_lim_q >= NOISE_MAX) ? NOISE_MIN
							: noise_lim_q + NOISE_STEP;
						ITEM_LIGHT: light_lim_d = (light_lim_q >= LIGHT_MAX) ? LIGHT_MIN
							: light_lim_q + LIGHT_STEP;
						default: ;
					endcase
				end
			end
			OP_DEC: begin
				if (menu_q) begin
					case (item_q)
						ITEM_TEMP:  temp_lim_d  = (temp_lim_q > TEMP_MIN)
							? temp_lim_q - 6'd1 : TEMP_MAX;
						ITEM_HUMID: humid_lim_d = (humid_lim_q > HUMID_MIN)
							? humid_lim_q - 7'd1 : HUMID_MAX;
						ITEM_GAS:   gas_lim_d   = (gas_lim_q > GAS_MIN)
							? gas_lim_q - GAS_STEP : GAS_MAX;
						ITEM_NOISE: noise_lim_d = (noise_lim_q > NOISE_MIN)
							? noise_lim_q - NOISE_STEP : NOISE_MAX;
						ITEM_LIGHT: light_lim_d = (light_lim_q > LIGHT_MIN)
							? light_lim_q - LIGHT_STEP : LIGHT_MAX;
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// Limit of the selected item after the event
	always_comb begin
		unique case (item_d)
			ITEM_TEMP:  item_value = {6'd0, temp_lim_d};
			ITEM_HUMID: item_value = {5'd0, humid_lim_d};
			ITEM_GAS:   item_value = gas_lim_d;
			ITEM_NOISE: item_value = {1'b0, noise_lim_d};
			ITEM_LIGHT: item_value = {3'd0, light_lim_d};
			default:    item_value = 12'd0;
		endcase
	end

	// Assemble the result
	always_comb begin
		result                = '0;
		result.in_menu        = menu_d;
		result.menu_item      = item_d;
		result.item_value     = item_value;
		result.humidity_alarm = humid_flag_d;
		result.heat_relay     = relay_flag_d;
		result.noise_alarm    = noise_flag_d;
		result.gas_alarm      = gas_flag_d;
		result.light_strong   = light_strong;
		result.motor_request  = motor_req;
		result.save_request   = save_req;
	end

	// Commit state when the event moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			menu_q       <= 1'b0;
			item_q       <= ITEM_TEMP;
			temp_lim_q   <= TEMP_RST;
			humid_lim_q  <= HUMID_RST;
			gas_lim_q    <= GAS_RST;
			noise_lim_q  <= NOISE_RST;
			light_lim_q  <= LIGHT_RST;
			humid_flag_q <= 1'b0;
			relay_flag_q <= 1'b0;
			noise_flag_q <= 1'b0;
			gas_flag_q   <= 1'b0;
		end else if (advance) begin
			menu_q       <= menu_d;
			item_q       <= item_d;
			temp_lim_q   <= temp_lim_d;
			humid_lim_q  <= humid_lim_d;
			gas_lim_q    <= gas_lim_d;
			noise_lim_q  <= noise_lim_d;
			light_lim_q  <= light_lim_d;
			humid_flag_q <= humid_flag_d;
			relay_flag_q <= relay_flag_d;
			noise_flag_q <= noise_flag_d;
			gas_flag_q   <= gas_flag_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

endmodule

/* hw/rtl/sawkm_checker.sv */
module sawkm_checker
	import sawkm_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     m_axis_tvalid,
	input logic                     m_axis_tready,
	input logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

	out_data_t res;

	assign res = out_data_t'(m_axis_tdata);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// Save pulse only on leaving the menu, back at the first item
	a_save: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.save_request |-> !res.in_menu && res.menu_item == ITEM_TEMP)
		else $error("save request outside a menu exit");

	// Sample pulses only on samples outside the menu
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res.light_strong || res.motor_request)
		|-> !res.in_menu && !res.save_request)
		else $error("sample pulse in the menu");

	// Exit item shows zero and only exists in the menu
	a_exit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.menu_item == ITEM_EXIT |-> res.in_menu && res.item_value == 12'd0)
		else $error("bad exit item result");

	// Item index stays in range
	a_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res.menu_item <= ITEM_EXIT)
		else $error("menu item out of range");

endmodule

bind sensor_alarm_with_key_menu sawkm_checker u_sawkm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import sawkm_pkg::*;

	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam logic [11:0] SAMPLE_MASK = 12'((1 << SAMPLE_BITS_DEF) - 1);

	// One event waiting for the driver, with the idle time that follows it
	typedef struct {
		op_t         kind;
		in_data_t    data;
		int unsigned gap;
		bit          calm;
	} menu_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = OP_SAMPLE;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;

	menu_event_t pending_events[$];
	out_data_t   expected_results[$];
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	int unsigned send_gap = 0;
	int unsigned rx_stall = 0;
	int unsigned rx_mood_timer = 0;
	int unsigned rx_mood = 0;
	bit          rx_quiet = 1'b0;

	// Predicted block state, reset values
	logic        menu_on = 1'b0;
	logic [2:0]  sel_item = ITEM_TEMP;
	logic [5:0]  lim_temp = TEMP_RST;
	logic [6:0]  lim_humid = HUMID_RST;
	logic [11:0] lim_gas = GAS_RST;
	logic [10:0] lim_noise = NOISE_RST;
	logic [8:0]  lim_light = LIGHT_RST;
	logic        humid_on = 1'b0;
	logic        relay_on = 1'b0;
	logic        noise_on = 1'b0;
	logic        gas_on = 1'b0;

	// Stimulus generator view of the menu, used to shape sequences
	bit          gen_menu = 1'b0;
	int unsigned gen_item = 0;
	int unsigned gen_mood = 0;
	bit          gen_calm = 1'b0;
	int unsigned effective_events = 0;

	sensor_alarm_with_key_menu u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Advance the alarm and menu state by one event and return its result
	function automatic out_data_t apply_event(op_t kind, in_data_t d);
		out_data_t r;
		logic      lstrong;
		logic      motor;
		logic      save;
		r = '0;
		lstrong = 1'b0;
		motor = 1'b0;
		save = 1'b0;
		case (kind)
			OP_SAMPLE: begin
				if (!menu_on) begin
					if (d.climate_valid) begin
						humid_on = d.humidity > lim_humid;
						motor = humid_on;
						relay_on = d.temperature > lim_temp;
					end
					noise_on = (d.noise_level & SAMPLE_MASK) > lim_noise;
					gas_on = (d.gas_level & SAMPLE_MASK) > lim_gas;
					lstrong = (d.light_level & SAMPLE_MASK) < lim_light;
				end
			end
			OP_SELECT: begin
				if (!menu_on) begin
					menu_on = 1'b1;
					sel_item = ITEM_TEMP;
				end else if (sel_item >= ITEM_EXIT) begin
					menu_on = 1'b0;
					sel_item = ITEM_TEMP;
					save = 1'b1;
				end else begin
					sel_item = sel_item + 3'd1;
				end
			end
			default: begin
				// Step the selected limit, wrapping at both ends of its range
				if (menu_on && kind == OP_INC) begin
					case (sel_item)
						ITEM_TEMP:  lim_temp = (int'(lim_temp) + 1 > int'(TEMP_MAX)) ?
							TEMP_MIN : lim_temp + 6'd1;
						ITEM_HUMID: lim_humid = (int'(lim_humid) + 1 > int'(HUMID_MAX)) ?
							HUMID_MIN : lim_humid + 7'd1;
						ITEM_GAS:   lim_gas = (int'(lim_gas) + int'(GAS_STEP) > int'(GAS_MAX)) ?
							GAS_MIN : lim_gas + GAS_STEP;
						ITEM_NOISE: lim_noise =
							(int'(lim_noise) + int'(NOISE_STEP) > int'(NOISE_MAX)) ?
							NOISE_MIN : lim_noise + NOISE_STEP;
						ITEM_LIGHT: lim_light =
							(int'(lim_light) + int'(LIGHT_STEP) > int'(LIGHT_MAX)) ?
							LIGHT_MIN : lim_light + LIGHT_STEP;
						default: ;
					endcase
				end else if (menu_on) begin
					case (sel_item)
						ITEM_TEMP:  lim_temp = (int'(lim_temp) >= int'(TEMP_MIN) + 1) ?
							lim_temp - 6'd1 : TEMP_MAX;
						ITEM_HUMID: lim_humid = (int'(lim_humid) >= int'(HUMID_MIN) + 1) ?
							lim_humid - 7'd1 : HUMID_MAX;
						ITEM_GAS:   lim_gas = (int'(lim_gas) >= int'(GAS_MIN) + int'(GAS_STEP)) ?
							lim_gas - GAS_STEP : GAS_MAX;
						ITEM_NOISE: lim_noise =
							(int'(lim_noise) >= int'(NOISE_MIN) + int'(NOISE_STEP)) ?
							lim_noise - NOISE_STEP : NOISE_MAX;
						ITEM_LIGHT: lim_light =
							(int'(lim_light) >= int'(LIGHT_MIN) + int'(LIGHT_STEP)) ?
							lim_light - LIGHT_STEP : LIGHT_MAX;
						default: ;
					endcase
				end
			end
		endcase
		r.in_menu = menu_on;
		r.menu_item = sel_item;
		case (sel_item)
			ITEM_TEMP:  r.item_value = 12'(lim_temp);
			ITEM_HUMID: r.item_value = 12'(lim_humid);
			ITEM_GAS:   r.item_value = lim_gas;
			ITEM_NOISE: r.item_value = 12'(lim_noise);
			ITEM_LIGHT: r.item_value = 12'(lim_light);
			default:    r.item_value = '0;
		endcase
		r.humidity_alarm = humid_on;
		r.heat_relay = relay_on;
		r.noise_alarm = noise_on;
		r.gas_alarm = gas_on;
		r.light_strong = lstrong;
		r.motor_request = motor;
		r.save_request = save;
		return r;
	endfunction

	function automatic in_data_t reading(logic cv, logic [7:0] hum, logic [7:0] temp,
			logic [11:0] gas, logic [11:0] noise, logic [11:0] light);
		in_data_t d;
		d = '0;
		d.climate_valid = cv;
		d.humidity = hum;
		d.temperature = temp;
		d.gas_level = gas;
		d.noise_level = noise;
		d.light_level = light;
		return d;
	endfunction

	// Draw readings either over the full field or close to the limit ranges
	function automatic in_data_t rand_reading(bit near);
		if (near)
			return reading($urandom_range(0, 3) != 0, 8'($urandom_range(55, 105)),
				8'($urandom_range(5, 45)), 12'($urandom_range(1900, 3100)),
				12'($urandom_range(900, 2100)), 12'($urandom_range(90, 310)));
		return reading($urandom_range(0, 3) != 0, 8'($urandom), 8'($urandom),
			12'($urandom), 12'($urandom), 12'($urandom));
	endfunction

	// Queue one event and track where the menu will stand after it
	task automatic put(op_t kind, in_data_t d);
		menu_event_t ev;
		bit          ignored;
		ev.kind = kind;
		ev.data = d;
		ev.calm = gen_calm;
		ev.gap = 0;
		if (!gen_calm && gen_mood != 0 && $urandom_range(0, gen_mood == 1 ? 15 : 3) == 0)
			ev.gap = $urandom_range(1, 16);
		pending_events.push_back(ev);
		ignored = (kind == OP_SAMPLE && gen_menu) ||
			((kind == OP_INC || kind == OP_DEC) && !gen_menu);
		if (kind == OP_SELECT) begin
			if (!gen_menu) begin
				gen_menu = 1'b1;
				gen_item = 0;
			end else if (gen_item >= 5) begin
				gen_menu = 1'b0;
				gen_item = 0;
			end else begin
				gen_item++;
			end
		end
		if (!ignored)
			effective_events++;
	endtask

	task automatic leave_menu();
		while (gen_menu)
			put(OP_SELECT, rand_reading(1'b0));
	endtask

	task automatic wait_drained();
		while (pending_events.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Drive input transfers from the event queue and predict each accepted one
	always @(posedge clk) begin
		menu_event_t ev;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(apply_event(op_t'(s_axis_tuser), in_data_t'(s_axis_tdata)));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_events.size() != 0) begin
					ev = pending_events.pop_front();
					s_axis_tuser <= ev.kind;
					s_axis_tdata <= ev.data;
					s_axis_tvalid <= 1'b1;
					send_gap <= ev.gap;
					rx_quiet <= ev.calm;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Stall the result side in bursts, with the burst rate changing now and then
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_mood_timer == 0) begin
				rx_mood_timer <= $urandom_range(50, 150);
				rx_mood <= $urandom_range(0, 2);
			end else begin
				rx_mood_timer <= rx_mood_timer - 1;
			end
			if (rx_stall != 0) begin
				rx_stall <= rx_stall - 1;
				m_axis_tready <= 1'b0;
			end else if (!rx_quiet && rx_mood != 0 &&
					$urandom_range(0, rx_mood == 1 ? 15 : 3) == 0) begin
				rx_stall <= $urandom_range(0, 15);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			if (mismatches < 10)
				$display("mismatch %s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		out_data_t want;
		out_data_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = out_data_t'(m_axis_tdata);
			if (expected_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("in_menu", want.in_menu, got.in_menu);
				check_field("menu_item", want.menu_item, got.menu_item);
				check_field("item_value", want.item_value, got.item_value);
				check_field("humidity_alarm", want.humidity_alarm, got.humidity_alarm);
				check_field("heat_relay", want.heat_relay, got.heat_relay);
				check_field("noise_alarm", want.noise_alarm, got.noise_alarm);
				check_field("gas_alarm", want.gas_alarm, got.gas_alarm);
				check_field("light_strong", want.light_strong, got.light_strong);
				check_field("motor_request", want.motor_request, got.motor_request);
				check_field("save_request", want.save_request, got.save_request);
				check_field("zero fill", want.pad, got.pad);
			end
		end
	end

	// End the run when no transfer moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned n;
		bit          up;
		// Directed: field extremes, ignored keys and samples, every wrap edge of the reset limits
		put(OP_SAMPLE, reading(1'b1, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF, 12'h000));
		put(OP_SAMPLE, reading(1'b1, 8'h00, 8'h00, 12'h000, 12'h000, 12'hFFF));
		put(OP_SAMPLE, reading(1'b1, 8'd91, 8'd21, 12'd2001, 12'd2001, 12'd299));
		put(OP_SAMPLE, reading(1'b0, 8'd90, 8'd20, 12'd2000, 12'd2000, 12'd300));
		put(OP_INC, reading(1'b1, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF, 12'hFFF));
		put(OP_DEC, reading(1'b0, 8'h00, 8'h00, 12'h000, 12'h000, 12'h000));
		put(OP_SELECT, '0);
		put(OP_DEC, '0);
		put(OP_INC, '0);
		put(OP_SAMPLE, reading(1'b1, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF, 12'h000));
		put(OP_SELECT, '0);
		put(OP_INC, '0);
		put(OP_SELECT, '0);
		put(OP_DEC, '0);
		put(OP_INC, '0);
		put(OP_SELECT, '0);
		put(OP_INC, '0);
		put(OP_SELECT, '0);
		put(OP_INC, '0);
		put(OP_SELECT, '0);
		put(OP_INC, '0);
		put(OP_DEC, '0);
		put(OP_SELECT, '0);
		put(OP_SAMPLE, reading(1'b1, 8'd91, 8'd21, 12'd3001, 12'd1001, 12'd99));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Hold off the random part until every directed result is back
		wait_drained();

		effective_events = 0;
		while (effective_events < 1000) begin
			gen_calm = effective_events >= 880;
			gen_mood = $urandom_range(0, 2);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					leave_menu();
					repeat ($urandom_range(1, 8))
						put(OP_SAMPLE, rand_reading($urandom_range(0, 2) != 0));
				end
				4, 5, 6, 7: begin
					// Full menu pass: enter, edit items, leave with a save
					leave_menu();
					put(OP_SELECT, rand_reading(1'b0));
					for (int it = 0; it < 6; it++) begin
						n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 35) : $urandom_range(0, 4);
						up = $urandom_range(0, 1);
						repeat (n) begin
							if ($urandom_range(0, 9) == 0)
								put(OP_SAMPLE, rand_reading(1'b0));
							else
								put(op_t'(up ? OP_INC : OP_DEC), rand_reading(1'b0));
						end
						put(OP_SELECT, rand_reading(1'b0));
					end
				end
				default: begin
					repeat ($urandom_range(1, 6))
						put(op_t'(2'($urandom_range(0, 3))), rand_reading($urandom_range(0, 1)));
				end
			endcase
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/sawkm_pkg.sv
hw/rtl/sensor_alarm_with_key_menu.sv
hw/rtl/sawkm_checker.sv
tb/tb_top.sv
